@@ rtl/ile_pkg.sv @@
// Shared types and constants of the indexed list engine.
package ile_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int FUNC_W    = 4;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH   = 4'd0,
		OP_POP    = 4'd1,
		OP_GET    = 4'd2,
		OP_SET    = 4'd3,
		OP_INSERT = 4'd4,
		OP_ERASE  = 4'd5,
		OP_CLEAR  = 4'd6,
		OP_FRONT  = 4'd7,
		OP_BACK   = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_FULL = 2'd2
	} res_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_UP,
		S_UP_DRAIN,
		S_UP_FILL,
		S_DN,
		S_DN_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_PTR,
		RD_FIRST,
		RD_LAST
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_POS,
		WR_TAIL,
		WR_UP,
		WR_DN
	} wr_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_LAST,
		PTR_AFTER_POS,
		PTR_DEC,
		PTR_INC
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        latch;
		logic        rd_en;
		rd_sel_t     rd_sel;
		logic        wr_en;
		wr_sel_t     wr_sel;
		ptr_op_t     ptr_op;
		cnt_op_t     cnt_op;
		logic        respond;
		res_status_t res_status;
		logic        res_word;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              empty;
		logic              full;
		logic              pos_lt;
		logic              pos_le;
		logic              pos_last;
		logic              up_end;
		logic              dn_end;
		logic              rd_valid;
	} dp_stat_t;

endpackage

@@ rtl/ile_ctrl.sv @@
// Controller state machine of the indexed list engine.
module ile_ctrl
	import ile_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = RD_POS;
		cmd.wr_sel     = WR_POS;
		cmd.ptr_op     = PTR_HOLD;
		cmd.cnt_op     = CNT_HOLD;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (stat.func)
					OP_PUSH: begin
						cmd.respond = 1'b1;
						if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_TAIL;
							cmd.cnt_op = CNT_INC;
						end
					end
					OP_POP: begin
						cmd.respond = 1'b1;
						if (stat.empty) begin
							cmd.res_status = ST_ERR;
						end else begin
							cmd.cnt_op = CNT_DEC;
						end
					end
					OP_GET: begin
						if (stat.pos_lt) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_READ;
						end else begin
							cmd.respond    = 1'b1;
							cmd.res_status = ST_ERR;
						end
					end
					OP_SET: begin
						cmd.respond = 1'b1;
						if (stat.pos_lt) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_POS;
						end else begin
							cmd.res_status = ST_ERR;
						end
					end
					OP_INSERT: begin
						if (!stat.pos_le) begin
							cmd.respond    = 1'b1;
							cmd.res_status = ST_ERR;
						end else if (stat.full) begin
							cmd.respond    = 1'b1;
							cmd.res_status = ST_FULL;
						end else if (!stat.pos_lt) begin
							// Insert at the tail needs no shift.
							cmd.respond = 1'b1;
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WR_POS;
							cmd.cnt_op  = CNT_INC;
						end else begin
							cmd.ptr_op = PTR_LAST;
							state_d    = S_UP;
						end
					end
					OP_ERASE: begin
						if (!stat.pos_lt) begin
							cmd.respond    = 1'b1;
							cmd.res_status = ST_ERR;
						end else if (stat.pos_last) begin
							// Erasing the last entry needs no shift.
							cmd.respond = 1'b1;
							cmd.cnt_op  = CNT_DEC;
						end else begin
							cmd.ptr_op = PTR_AFTER_POS;
							state_d    = S_DN;
						end
					end
					OP_CLEAR: begin
						cmd.respond = 1'b1;
						cmd.cnt_op  = CNT_CLR;
					end
					OP_FRONT, OP_BACK: begin
						if (stat.empty) begin
							cmd.respond    = 1'b1;
							cmd.res_status = ST_ERR;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = (stat.func == OP_FRONT) ? RD_FIRST : RD_LAST;
							state_d    = S_READ;
						end
					end
					default: begin
						cmd.respond    = 1'b1;
						cmd.res_status = ST_ERR;
					end
				endcase
			end
			S_READ: begin
				cmd.respond  = 1'b1;
				cmd.res_word = 1'b1;
				state_d      = S_IDLE;
			end
			S_UP: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
				cmd.ptr_op = PTR_DEC;
				cmd.wr_en  = stat.rd_valid;
				cmd.wr_sel = WR_UP;
				if (stat.up_end) begin
					state_d = S_UP_DRAIN;
				end
			end
			S_UP_DRAIN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_UP;
				state_d    = S_UP_FILL;
			end
			S_UP_FILL: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_POS;
				cmd.cnt_op  = CNT_INC;
				cmd.respond = 1'b1;
				state_d     = S_IDLE;
			end
			S_DN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
				cmd.ptr_op = PTR_INC;
				cmd.wr_en  = stat.rd_valid;
				cmd.wr_sel = WR_DN;
				if (stat.dn_end) begin
					state_d = S_DN_DRAIN;
				end
			end
			S_DN_DRAIN: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_DN;
				cmd.cnt_op  = CNT_DEC;
				cmd.respond = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/ile_datapath.sv @@
// Datapath of the indexed list engine: entry memory, count, pointer and result registers.
module ile_datapath
	import ile_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [FUNC_W-1:0]    func,
	input  logic [ADDR_W-1:0]    position,
	input  logic [WORD_BITS-1:0] word_in,
	output dp_stat_t             stat,
	output logic                 done,
	output logic [WORD_BITS-1:0] word_out,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     count
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	logic [FUNC_W-1:0]    func_q;
	logic [ADDR_W-1:0]    pos_q;
	logic [WORD_BITS-1:0] word_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [WORD_BITS-1:0] rd_data_s1;
	logic [ADDR_W-1:0]    rd_addr_s1;
	logic                 rd_valid_s1;
	logic [WORD_BITS-1:0] word_out_q;
	res_status_t          status_q;
	logic                 done_q;

	logic [ADDR_W-1:0]    last_addr;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [CNT_W-1:0]     pos_ext;

	assign last_addr = ADDR_W'(count_q - CNT_W'(1));
	assign pos_ext   = CNT_W'(pos_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			pos_q  <= position;
			word_q <= word_in;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_POS:   rd_addr = pos_q;
			RD_PTR:   rd_addr = ptr_q;
			RD_FIRST: rd_addr = '0;
			RD_LAST:  rd_addr = last_addr;
			default:  rd_addr = pos_q;
		endcase
	end

	always_comb begin
		wr_data = rd_data_s1;
		case (cmd.wr_sel)
			WR_POS: begin
				wr_addr = pos_q;
				wr_data = word_q;
			end
			WR_TAIL: begin
				wr_addr = ADDR_W'(count_q);
				wr_data = word_q;
			end
			WR_UP:   wr_addr = rd_addr_s1 + ADDR_W'(1);
			WR_DN:   wr_addr = rd_addr_s1 - ADDR_W'(1);
			default: wr_addr = pos_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.ptr_op)
			PTR_LAST:      ptr_q <= last_addr;
			PTR_AFTER_POS: ptr_q <= pos_q + ADDR_W'(1);
			PTR_DEC:       ptr_q <= ptr_q - ADDR_W'(1);
			PTR_INC:       ptr_q <= ptr_q + ADDR_W'(1);
			default:       ptr_q <= ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			word_out_q <= cmd.res_word ? rd_data_s1 : '0;
			status_q   <= cmd.res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			done_q      <= cmd.respond;
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= count_q - CNT_W'(1);
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
		end
	end

	assign stat.func     = func_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q >= CNT_W'(DEPTH));
	assign stat.pos_lt   = (pos_ext < count_q);
	assign stat.pos_le   = (pos_ext <= count_q);
	assign stat.pos_last = ((pos_ext + CNT_W'(1)) == count_q);
	assign stat.up_end   = (ptr_q == pos_q);
	assign stat.dn_end   = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	assign stat.rd_valid = rd_valid_s1;

	assign done     = done_q;
	assign word_out = word_out_q;
	assign status   = status_q;
	assign count    = count_q;

endmodule

@@ rtl/indexed_list_engine_top.sv @@
// Top level of the indexed list engine: controller and datapath.
//
// The indexed list engine keeps an ordered list of up to 64 words of 32 bits and runs one
// operation per command: push, pop, get, set, insert, erase, clear, front and back. A command
// transfer happens at a rising edge where start is high and busy is low; func, position and
// word_in are sampled there. Each command yields exactly one result, shown on word_out, status
// and count for a single cycle while done is high. The receiver cannot stall: it must take the
// result in that cycle. The result of one command appears before the next can be taken, and
// busy drops in the same cycle as done, so a new command may follow at once.
// Push, pop, set, clear, failed commands, insert at the tail and erase of the last entry reply
// from the decode state; get, front and back reply from a read state after it, because of
// the registered read of the entry memory. Insert and erase move the entries behind
// the position one per cycle through the single read and single write port of the memory,
// so the longest command is an insert at position 0 into a list of 63 entries. The
// memory needs no clearing pass after reset.
module indexed_list_engine_top
	import ile_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [ADDR_W-1:0]    position,
	input  logic [WORD_BITS-1:0] word_in,
	output logic                 done,
	output logic [WORD_BITS-1:0] word_out,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     count
);

	// Commands and status between the two halves.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller sequences each operation, including the shift loops of insert and erase.
	ile_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the entry memory, the entry count and the result registers.
	ile_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.func     (func),
		.position (position),
		.word_in  (word_in),
		.stat     (stat),
		.done     (done),
		.word_out (word_out),
		.status   (status),
		.count    (count)
	);

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the indexed list engine.
`timescale 1ns / 100ps

// The testbench drives commands through the start/busy handshake and keeps its own model
// of the list. The model is a word array and an entry count. Every accepted command
// transfer updates the model at once, and the reply that the model predicts is queued.
// Each reply transfer, marked by done, is compared field by field with the oldest queued
// reply. The stimulus starts with directed commands on an empty and a nearly empty list,
// and then fills the list to capacity. Random phases follow, with different mixes of
// growing and shrinking operations and with or without gaps between commands.
module tb;
	import ile_pkg::*;

	// Operation codes 9 to 15 are not used by the block and must be rejected.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd9;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

	// The slowest correct run is roughly 850 commands, each after the longest gap and
	// taking as long as the longest command. The limit is several times that run.
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		res_status_t          status;
		logic [CNT_W-1:0]     count;
	} list_reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [FUNC_W-1:0]    func;
	logic [ADDR_W-1:0]    position;
	logic [WORD_BITS-1:0] word_in;
	logic                 done;
	logic [WORD_BITS-1:0] word_out;
	logic [1:0]           status;
	logic [CNT_W-1:0]     count;

	// This is the model of the list contents. Only entries below list_len are ever read.
	logic [WORD_BITS-1:0] list_words [DEPTH];
	int                   list_len;

	list_reply_t          replies_due[$];
	list_reply_t          oldest_reply;

	int  fail_count;
	int  cycle_count;
	int  op_hits [1 << FUNC_W];
	int  full_replies;
	int  error_replies;
	int  peak_len;
	bit  steady_sender;

	indexed_list_engine_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.position (position),
		.word_in  (word_in),
		.done     (done),
		.word_out (word_out),
		.status   (status),
		.count    (count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// This is the watchdog. A hung handshake or a missing reply ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The model applies one command to the list and returns the reply that the block
	// owes for it. Index checks come before the capacity check, so an insert past
	// the end of a full list reports an error and not full.
	function automatic list_reply_t apply_list_op(input logic [FUNC_W-1:0] f,
			input logic [ADDR_W-1:0] p, input logic [WORD_BITS-1:0] w);
		list_reply_t r;
		int          i;
		r.word   = '0;
		r.status = ST_OK;
		case (f)
			OP_PUSH: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_len] = w;
					list_len++;
				end
			end
			OP_POP: begin
				if (list_len == 0) r.status = ST_ERR;
				else list_len--;
			end
			OP_GET: begin
				if (p >= list_len) r.status = ST_ERR;
				else r.word = list_words[p];
			end
			OP_SET: begin
				if (p >= list_len) r.status = ST_ERR;
				else list_words[p] = w;
			end
			OP_INSERT: begin
				if (p > list_len) begin
					r.status = ST_ERR;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
					list_words[p] = w;
					list_len++;
				end
			end
			OP_ERASE: begin
				if (p >= list_len) begin
					r.status = ST_ERR;
				end else begin
					for (i = p; i < list_len - 1; i++) list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			OP_FRONT: begin
				if (list_len == 0) r.status = ST_ERR;
				else r.word = list_words[0];
			end
			OP_BACK: begin
				if (list_len == 0) r.status = ST_ERR;
				else r.word = list_words[list_len-1];
			end
			default: begin
				r.status = ST_ERR;
			end
		endcase
		r.count = CNT_W'(list_len);
		return r;
	endfunction

	// Most gaps are zero or short. A few are longer than the slowest command, so
	// that idle periods land on every phase of a shift.
	function automatic int pick_gap();
		int r;
		if (steady_sender) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 20);
		return $urandom_range(21, 80);
	endfunction

	function automatic logic [FUNC_W-1:0] pick_func(input int grow_pct, input int shrink_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < grow_pct) return $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
		if (r < grow_pct + shrink_pct) return $urandom_range(0, 1) ? OP_POP : OP_ERASE;
		r = $urandom_range(0, 39);
		if (r < 14) return OP_GET;
		if (r < 26) return OP_SET;
		if (r < 30) return OP_FRONT;
		if (r < 34) return OP_BACK;
		if (r < 35) return OP_CLEAR;
		return FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
	endfunction

	// Most positions are valid for the current length, and the two ends of the list are
	// favored. The remaining positions are drawn from the whole field, so errors occur too.
	function automatic logic [ADDR_W-1:0] pick_position(input logic [FUNC_W-1:0] f);
		int hi;
		if ($urandom_range(0, 9) < 2) return ADDR_W'($urandom_range(0, DEPTH - 1));
		hi = (f == OP_INSERT) ? list_len : list_len - 1;
		if (hi > DEPTH - 1) hi = DEPTH - 1;
		if (hi < 0) hi = 0;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ADDR_W'(hi);
			default: return ADDR_W'($urandom_range(0, hi));
		endcase
	endfunction

	// This task sends one command. Start stays high from the previous command when
	// there is no gap. The command transfer happens at the first edge with busy low.
	// The model is updated at that edge.
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] p,
			input logic [WORD_BITS-1:0] w);
		int          gap;
		list_reply_t reply;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		func     <= f;
		position <= p;
		word_in  <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		reply = apply_list_op(f, p, w);
		replies_due.push_back(reply);
		op_hits[f]++;
		if (reply.status == ST_FULL) full_replies++;
		if (reply.status == ST_ERR) error_replies++;
		if (list_len > peak_len) peak_len = list_len;
	endtask

	// The sender holds off until every outstanding reply has arrived. Every
	// command yields a reply, so the block is idle after that. At least one edge
	// passes, so start is never lowered and raised again within one time step.
	task automatic drain_replies();
		start <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);
	endtask

	// These commands cover the empty list, insert into the empty list and in the middle,
	// reads at index 0 and past the last valid index, the unused operation codes, and clear.
	task automatic test_empty_and_edges();
		send_cmd(OP_POP, 0, 0);
		send_cmd(OP_FRONT, 0, 0);
		send_cmd(OP_BACK, 0, 0);
		send_cmd(OP_GET, 0, 0);
		send_cmd(OP_SET, 0, 32'h1234_5678);
		send_cmd(OP_ERASE, 0, 0);
		send_cmd(OP_INSERT, 1, 32'hDEAD_BEEF);
		send_cmd(OP_INSERT, 0, 32'hFFFF_FFFF);
		send_cmd(OP_PUSH, 6'h3F, 32'h0000_0000);
		send_cmd(OP_PUSH, 0, 32'hAAAA_5555);
		send_cmd(OP_INSERT, 3, 32'h5555_AAAA);
		send_cmd(OP_INSERT, 1, 32'h0F0F_F0F0);
		send_cmd(OP_GET, 0, 0);
		send_cmd(OP_GET, 4, 0);
		send_cmd(OP_GET, 5, 0);
		send_cmd(OP_GET, 6'h3F, 0);
		send_cmd(OP_SET, 2, 32'h8000_0001);
		send_cmd(OP_FRONT, 0, 0);
		send_cmd(OP_BACK, 0, 0);
		send_cmd(OP_ERASE, 0, 0);
		send_cmd(OP_ERASE, 3, 0);
		send_cmd(FUNC_UNUSED_LO, 0, 32'hFFFF_FFFF);
		send_cmd(FUNC_UNUSED_HI, 6'h3F, 0);
		send_cmd(OP_CLEAR, 6'h3F, 32'hFFFF_FFFF);
		send_cmd(OP_BACK, 0, 0);
	endtask

	// This test fills the list to capacity and then tries to grow it further. It
	// also runs the longest shifts in both directions.
	task automatic test_full_list();
		int i;
		send_cmd(OP_CLEAR, 0, 0);
		for (i = 0; i < DEPTH; i++) send_cmd(OP_PUSH, pick_position(OP_PUSH), $urandom());
		send_cmd(OP_PUSH, 0, $urandom());
		send_cmd(OP_INSERT, 0, $urandom());
		send_cmd(OP_INSERT, 6'h3F, $urandom());
		send_cmd(OP_GET, 6'h3F, 0);
		send_cmd(OP_BACK, 0, 0);
		send_cmd(OP_ERASE, 0, 0);
		send_cmd(OP_INSERT, 0, $urandom());
		send_cmd(OP_FRONT, 0, 0);
		send_cmd(OP_ERASE, 6'h3F, 0);
		send_cmd(OP_INSERT, 6'h3F, $urandom());
		send_cmd(OP_BACK, 0, 0);
		send_cmd(OP_CLEAR, 0, 0);
		send_cmd(OP_POP, 0, 0);
	endtask

	// This test sends random commands with the given share of growing and
	// shrinking operations. Unused codes are sent as well, but they do not count
	// toward n_cmds.
	task automatic test_random_mix(input int n_cmds, input int grow_pct, input int shrink_pct,
			input bit steady);
		int                sent;
		logic [FUNC_W-1:0] f;
		steady_sender = steady;
		sent = 0;
		while (sent < n_cmds) begin
			f = pick_func(grow_pct, shrink_pct);
			send_cmd(f, pick_position(f), $urandom());
			if (f <= OP_BACK) sent++;
		end
		steady_sender = 1'b0;
	endtask

	// Each reply transfer is checked against the oldest outstanding prediction.
	// The outputs are sampled at the edge that ends the done cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("reply with no command outstanding: word_out %h status %0d count %0d",
					word_out, status, count);
				fail_count++;
			end else begin
				oldest_reply = replies_due.pop_front();
				if (word_out !== oldest_reply.word) begin
					$error("word_out mismatch: expected %h, actual %h",
						oldest_reply.word, word_out);
					fail_count++;
				end
				if (status !== oldest_reply.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						oldest_reply.status, status);
					fail_count++;
				end
				if (count !== oldest_reply.count) begin
					$error("count mismatch: expected %0d, actual %0d",
						oldest_reply.count, count);
					fail_count++;
				end
			end
		end
	end

	initial begin
		start         <= 1'b0;
		func          <= OP_PUSH;
		position      <= '0;
		word_in       <= '0;
		arst_n        <= 1'b0;
		fail_count    = 0;
		cycle_count   = 0;
		full_replies  = 0;
		error_replies = 0;
		peak_len      = 0;
		steady_sender = 1'b0;
		list_len      = 0;
		foreach (op_hits[i]) op_hits[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_and_edges();
		drain_replies();
		test_full_list();
		drain_replies();
		// The list grows until it is full. Push and insert then see full replies.
		test_random_mix(210, 45, 15, 1'b0);
		drain_replies();
		// This phase is balanced and has no gaps, so commands follow back to back.
		test_random_mix(210, 30, 30, 1'b1);
		drain_replies();
		// The list shrinks toward empty, so error replies become common.
		test_random_mix(170, 25, 40, 1'b0);
		drain_replies();
		test_random_mix(125, 35, 35, 1'b0);
		drain_replies();

		// A stray late reply would be caught by the checker in this window.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Commands: %0d push, %0d pop, %0d get, %0d set, %0d insert, %0d erase,",
			op_hits[OP_PUSH], op_hits[OP_POP], op_hits[OP_GET], op_hits[OP_SET],
			op_hits[OP_INSERT], op_hits[OP_ERASE]);
		$display("%0d clear, %0d front, %0d back; %0d full and %0d error replies; peak %0d of %0d.",
			op_hits[OP_CLEAR], op_hits[OP_FRONT], op_hits[OP_BACK], full_replies,
			error_replies, peak_len, DEPTH);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/ile_pkg.sv
rtl/ile_ctrl.sv
rtl/ile_datapath.sv
rtl/indexed_list_engine_top.sv
sim/tb.sv
